// ===== design/b64sc_pkg.sv =====
// Package for the base64 stream codec: widths, mode codes and the
// alphabet mapping functions. Depends on nothing else.
package b64sc_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned SextetW = 6;
	localparam int unsigned GroupW  = 24;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	localparam logic [ByteW-1:0] PadChar = 8'h3D;

	// Maps a sextet onto its alphabet character.
	function automatic logic [ByteW-1:0] sextet_to_char(input logic [SextetW-1:0] v);
		logic [ByteW-1:0] w;
		logic [ByteW-1:0] r;
		w = {2'b00, v};
		if (v < 6'd26) begin
			r = 8'h41 + w;
		end else if (v < 6'd52) begin
			r = 8'h61 + w - 8'd26;
		end else if (v < 6'd62) begin
			r = 8'h30 + w - 8'd52;
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

	// Maps a character onto its sextet; characters outside the alphabet give 0.
	function automatic logic [SextetW-1:0] char_to_sextet(input logic [ByteW-1:0] c);
		logic [SextetW-1:0] r;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = SextetW'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = SextetW'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = SextetW'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r = 6'd62;
		end else if (c == 8'h2F) begin
			r = 6'd63;
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

// ===== design/base64_stream_codec.sv =====
// Top level of the base64 stream codec: group collection, the per-item encode/decode
// logic and a four-entry result register drained one beat a cycle while out_stall
// is low. Uses b64sc_pkg for widths, mode codes and the alphabet functions.
//
//   channel  direction  handshake          payload
//   cfg      in         cfg_valid/ready    cfg_data (mode)
//   in       in         in_valid/in_stall  data_byte, last
//   out      out        out_valid/stall    out_byte, out_last, bad_end
//
// An input beat is folded into the group state in the cycle it is accepted;
// its results (up to four) sit in the result register from the next cycle
// and leave one per cycle while out_stall is low. Beats that make no result are
// taken at any time; the result register sets the encoding rate, and encoding
// takes a group's bytes while the last group's characters drain. Decoding takes
// one character per cycle while out_stall is low; a group's three bytes drain meanwhile.
// Reset (arst_n low) clears mode to encode and empties group and results.
// A full result register stalls the input side only for a beat that makes results.
module base64_stream_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       bad_end
);

	b64sc_pkg::mode_t                   mode_q;
	logic [b64sc_pkg::GroupW-1:0]       group_bits_q;
	logic [1:0]                         group_count_q;
	logic [1:0]                         pad_seen_q;

	logic [b64sc_pkg::ByteW-1:0]        res_byte_q [4];
	logic [2:0]                         res_rem_q;
	logic [1:0]                         res_pos_q;
	logic                               res_last_q;
	logic                               res_bad_q;

	logic [b64sc_pkg::GroupW-1:0]       nx_bits;
	logic [1:0]                         nx_count;
	logic [1:0]                         nx_pad;
	logic [2:0]                         nx_n;
	logic                               nx_bad;
	logic [b64sc_pkg::ByteW-1:0]        nx_byte [4];

	logic [b64sc_pkg::GroupW-1:0]       enc_group;
	logic [b64sc_pkg::GroupW-1:0]       enc_bits;
	logic [b64sc_pkg::GroupW-1:0]       dec_group;
	logic [2:0]                         cnt;
	logic [1:0]                         pad_inc;
	logic [2:0]                         nchar;
	logic [2:0]                         nbytes;

	logic in_fire;
	logic out_fire;
	logic res_free;

	assign cfg_ready = 1'b1;
	assign out_valid = (res_rem_q != 3'd0);
	assign out_byte  = res_byte_q[res_pos_q];
	assign out_last  = res_last_q && (res_rem_q == 3'd1);
	assign bad_end   = res_bad_q;
	assign out_fire  = out_valid && !out_stall;
	// The result register can take a new set of results in this cycle.
	assign res_free  = (res_rem_q == 3'd0) || ((res_rem_q == 3'd1) && !out_stall);
	assign in_stall  = !res_free && (nx_n != 3'd0);
	assign in_fire   = in_valid && !in_stall;

	always_comb begin
		cnt       = {1'b0, group_count_q} + 3'd1;
		enc_group = {group_bits_q[15:0], data_byte};
		dec_group = {group_bits_q[17:0], b64sc_pkg::char_to_sextet(data_byte)};
		pad_inc   = (pad_seen_q == 2'd3) ? 2'd3 : pad_seen_q + 2'd1;
		nx_bits   = '0;
		nx_count  = '0;
		nx_pad    = '0;
		nx_n      = '0;
		nx_bad    = 1'b0;
		enc_bits  = '0;
		nchar     = '0;
		nbytes    = '0;
		for (int i = 0; i < 4; i++) begin
			nx_byte[i] = '0;
		end
		case (mode_q)
			b64sc_pkg::MODE_ENCODE: begin
				case (cnt)
					3'd1:    enc_bits = {data_byte, 16'h0000};
					3'd2:    enc_bits = {enc_group[15:0], 8'h00};
					default: enc_bits = enc_group;
				endcase
				nchar = cnt + 3'd1;
				if (cnt == 3'd3 || last) begin
					nx_n = 3'd4;
					for (int i = 0; i < 4; i++) begin
						nx_byte[i] = (3'(i) < nchar)
							? b64sc_pkg::sextet_to_char(enc_bits[23-6*i -: 6])
							: b64sc_pkg::PadChar;
					end
				end else begin
					nx_bits  = enc_group;
					nx_count = cnt[1:0];
				end
			end
			b64sc_pkg::MODE_DECODE: begin
				nx_pad = (data_byte == b64sc_pkg::PadChar) ? pad_inc : pad_seen_q;
				nbytes = (nx_pad == 2'd3) ? 3'd0 : 3'd3 - {1'b0, nx_pad};
				nx_byte[0] = dec_group[23:16];
				nx_byte[1] = dec_group[15:8];
				nx_byte[2] = dec_group[7:0];
				if (cnt != 3'd4) begin
					if (last) begin
						nx_n       = 3'd1;
						nx_bad     = 1'b1;
						nx_byte[0] = '0;
						nx_pad     = '0;
					end else begin
						nx_bits  = dec_group;
						nx_count = cnt[1:0];
					end
				end else begin
					nx_pad = '0;
					if (nbytes == 3'd0 && last) begin
						nx_n       = 3'd1;
						nx_bad     = 1'b1;
						nx_byte[0] = '0;
					end else begin
						nx_n = nbytes;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= b64sc_pkg::MODE_ENCODE;
			group_bits_q  <= '0;
			group_count_q <= '0;
			pad_seen_q    <= '0;
			res_rem_q     <= '0;
			res_pos_q     <= '0;
			res_last_q    <= 1'b0;
			res_bad_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q        <= b64sc_pkg::mode_t'(cfg_data);
				group_bits_q  <= '0;
				group_count_q <= '0;
				pad_seen_q    <= '0;
			end else if (in_fire) begin
				group_bits_q  <= nx_bits;
				group_count_q <= nx_count;
				pad_seen_q    <= nx_pad;
			end
			if (in_fire && nx_n != 3'd0) begin
				res_rem_q  <= nx_n;
				res_pos_q  <= '0;
				res_last_q <= last;
				res_bad_q  <= nx_bad;
			end else if (out_fire) begin
				res_rem_q <= res_rem_q - 3'd1;
				res_pos_q <= res_pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && nx_n != 3'd0) begin
			for (int i = 0; i < 4; i++) begin
				res_byte_q[i] <= nx_byte[i];
			end
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_rem_q <= 3'd4)
		else $error("result count out of range");

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_end |-> out_last && res_rem_q == 3'd1)
		else $error("bad_end beat is not the final beat");

	a_enc_no_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q == b64sc_pkg::MODE_ENCODE |-> !bad_end)
		else $error("bad_end raised while encoding");

	a_enc_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == b64sc_pkg::MODE_ENCODE |-> group_count_q != 2'd3)
		else $error("encode group holds more than two bytes");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && nx_n != 3'd0 |=> out_valid)
		else $error("results of an accepted beat did not appear");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for base64_stream_codec: directed table, then random messages
// in both modes, scored against an in-file predictor of the codec.
// Depends on b64sc_pkg and the base64_stream_codec RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] b;
		logic       lst;
		logic       bad;
	} b64_beat_t;

	typedef struct packed {
		logic              wr;
		b64sc_pkg::mode_t  m;
		logic [7:0]        data;
		logic              lst;
		logic              typed;
		logic [2:0]        n;
		logic [31:0]       bytes;
		logic              bad;
	} dir_row_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_kind_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       bad_end;

	string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// Predictor state.
	b64sc_pkg::mode_t codec_mode = b64sc_pkg::MODE_ENCODE;
	logic [23:0] grp_bits = '0;
	logic [1:0]  grp_cnt = '0;
	logic [1:0]  grp_pads = '0;

	b64_beat_t   due_beats[$];
	dir_row_t    dir_rows[$];
	b64_beat_t   want;
	int          fail_cnt = 0;
	int          burst_left = 0;
	int          beats_sent = 0;
	stall_kind_t stall_kind = STALL_NONE;
	int          stall_cnt = 0;

	base64_stream_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.bad_end   (bad_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Folds one accepted input beat into the predicted group state and, when keep is set,
	// queues the output beats it produces.
	function automatic void advance_codec(input logic [7:0] d, input logic l, input bit keep);
		int          cnt;
		int          nout;
		logic [23:0] bits;
		logic [5:0]  sx;
		b64_beat_t   r;
		r = '0;
		if (codec_mode == b64sc_pkg::MODE_ENCODE) begin
			grp_bits = {grp_bits[15:0], d};
			cnt = grp_cnt + 1;
			if (cnt < 3 && !l) begin
				grp_cnt = cnt[1:0];
				return;
			end
			// Left-align a short group so the sextets read from the top.
			bits = grp_bits << (8 * (3 - cnt));
			for (int i = 0; i < 4; i++) begin
				if (i <= cnt) begin
					r.b = b64_chars[bits[23 - 6*i -: 6]];
				end else begin
					r.b = b64sc_pkg::PadChar;
				end
				r.lst = l && (i == 3);
				r.bad = 1'b0;
				if (keep) due_beats.push_back(r);
			end
		end else begin
			sx = '0;
			for (int k = 0; k < 64; k++) begin
				if (b64_chars[k] == d) sx = 6'(k);
			end
			if (d == b64sc_pkg::PadChar && grp_pads != 2'd3) grp_pads = grp_pads + 2'd1;
			grp_bits = {grp_bits[17:0], sx};
			cnt = grp_cnt + 1;
			if (cnt < 4) begin
				if (!l) begin
					grp_cnt = cnt[1:0];
					return;
				end
				r.b = 8'h00;
				r.lst = 1'b1;
				r.bad = 1'b1;
				if (keep) due_beats.push_back(r);
			end else begin
				nout = (grp_pads <= 2'd2) ? 3 - grp_pads : 0;
				for (int i = 0; i < nout; i++) begin
					r.b = grp_bits[23 - 8*i -: 8];
					r.lst = l && (i == nout - 1);
					r.bad = 1'b0;
					if (keep) due_beats.push_back(r);
				end
				if (l && nout == 0) begin
					r.b = 8'h00;
					r.lst = 1'b1;
					r.bad = 1'b1;
					if (keep) due_beats.push_back(r);
				end
			end
		end
		grp_bits = '0;
		grp_cnt = '0;
		grp_pads = '0;
	endfunction

	task automatic add_row(input bit wr, input b64sc_pkg::mode_t m, input logic [7:0] d,
			input bit l, input bit typed, input int n, input logic [31:0] bytes,
			input bit bad);
		dir_row_t row;
		row.wr = wr;
		row.m = m;
		row.data = d;
		row.lst = l;
		row.typed = typed;
		row.n = 3'(n);
		row.bytes = bytes;
		row.bad = bad;
		dir_rows.push_back(row);
	endtask

	task automatic send_beat(input logic [7:0] d, input logic l, input bit keep);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= d;
		last <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		advance_codec(d, l, keep);
		beats_sent++;
	endtask

	task automatic drain_out();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_beats.size() != 0) @(negedge clk);
	endtask

	// Leave the codec idle after the last output beat before the mode write.
	task automatic set_mode(input b64sc_pkg::mode_t m);
		drain_out();
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		codec_mode = m;
		grp_bits = '0;
		grp_cnt = '0;
		grp_pads = '0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_cnt == 0) begin
			case ($urandom_range(0, 3))
				0: stall_kind = STALL_NONE;
				1: stall_kind = STALL_LIGHT;
				2: stall_kind = STALL_HEAVY;
				default: stall_kind = STALL_PERIODIC;
			endcase
			stall_cnt = $urandom_range(20, 80);
		end else begin
			stall_cnt = stall_cnt - 1;
		end
		case (stall_kind)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_cnt % 3 != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_beats.size() == 0) begin
				if (fail_cnt < 10) begin
					$display("unexpected output beat: out_byte %h out_last %b bad_end %b",
						out_byte, out_last, bad_end);
				end
				fail_cnt++;
			end else begin
				want = due_beats.pop_front();
				if (out_byte !== want.b || out_last !== want.lst || bad_end !== want.bad) begin
					if (fail_cnt < 10) begin
						$display("mismatch: out_byte %h/%h out_last %b/%b bad_end %b/%b (exp/act)",
							want.b, out_byte, want.lst, out_last, want.bad, bad_end);
					end
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL base64_stream_codec");
		$finish;
	end

	initial begin
		dir_row_t         row;
		b64_beat_t        r;
		b64sc_pkg::mode_t m;
		int               rand_start;
		int               phase_start;
		int               phase_len;
		int               len;
		int               ng;
		int               npad;
		int               phase;
		logic [7:0]       ch;

		// Encode: one full group, one- and two-byte endings, a full group mid-message.
		add_row(1, b64sc_pkg::MODE_ENCODE, 8'h4D, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_ENCODE, 8'h61, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_ENCODE, 8'h6E, 1, 1, 4, 32'h5457_4675, 0);
		add_row(0, b64sc_pkg::MODE_ENCODE, 8'hFF, 1, 1, 4, 32'h2F77_3D3D, 0);
		add_row(0, b64sc_pkg::MODE_ENCODE, 8'h00, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_ENCODE, 8'h00, 1, 1, 4, 32'h4141_413D, 0);
		add_row(0, b64sc_pkg::MODE_ENCODE, 8'hFF, 0, 0, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_ENCODE, 8'hFF, 0, 0, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_ENCODE, 8'hFF, 0, 1, 4, 32'h2F2F_2F2F, 0);
		// Decode: plain group, two pads, short ending, too many pads.
		add_row(1, b64sc_pkg::MODE_DECODE, 8'h54, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, 8'h57, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, 8'h46, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, 8'h75, 1, 1, 3, 32'h4D61_6E00, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, 8'h2F, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, 8'h77, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, b64sc_pkg::PadChar, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, b64sc_pkg::PadChar, 1, 1, 1, 32'hFF00_0000, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, 8'h41, 1, 1, 1, 32'h0, 1);
		add_row(0, b64sc_pkg::MODE_DECODE, 8'h41, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, b64sc_pkg::PadChar, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, b64sc_pkg::PadChar, 0, 1, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, b64sc_pkg::PadChar, 1, 1, 1, 32'h0, 1);
		// A pad in the middle of a mid-message group, unknown characters, then a short end.
		add_row(0, b64sc_pkg::MODE_DECODE, 8'h2F, 0, 0, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, b64sc_pkg::PadChar, 0, 0, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, 8'hFF, 0, 0, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, 8'h39, 0, 0, 0, 32'h0, 0);
		add_row(0, b64sc_pkg::MODE_DECODE, 8'h00, 1, 0, 0, 32'h0, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.wr) set_mode(row.m);
			send_beat(row.data, row.lst, !row.typed);
			if (row.typed) begin
				for (int k = 0; k < row.n; k++) begin
					r.b = row.bytes[31 - 8*k -: 8];
					r.lst = row.lst && (k == row.n - 1);
					r.bad = row.bad;
					due_beats.push_back(r);
				end
			end
		end

		rand_start = beats_sent;
		phase = 0;
		while (beats_sent - rand_start < 90) begin
			if (phase == 0) begin
				m = b64sc_pkg::MODE_ENCODE;
			end else if (phase == 1) begin
				m = b64sc_pkg::MODE_DECODE;
			end else begin
				m = ($urandom_range(0, 1) == 0) ? b64sc_pkg::MODE_ENCODE
					: b64sc_pkg::MODE_DECODE;
			end
			set_mode(m);
			phase_start = beats_sent;
			phase_len = $urandom_range(15, 30);
			while (beats_sent - phase_start < phase_len) begin
				if (m == b64sc_pkg::MODE_ENCODE) begin
					len = $urandom_range(1, 10);
					for (int k = 0; k < len; k++) begin
						send_beat(8'($urandom_range(0, 255)), k == len - 1, 1);
					end
				end else if ($urandom_range(0, 3) != 0) begin
					// Well-formed text: whole groups, pads only at the end.
					ng = $urandom_range(1, 3);
					npad = $urandom_range(0, 2);
					for (int g = 0; g < ng; g++) begin
						for (int k = 0; k < 4; k++) begin
							if (g == ng - 1 && k >= 4 - npad) begin
								ch = b64sc_pkg::PadChar;
							end else begin
								ch = b64_chars[$urandom_range(0, 63)];
							end
							send_beat(ch, (g == ng - 1) && (k == 3), 1);
						end
					end
				end else begin
					len = $urandom_range(1, 9);
					for (int k = 0; k < len; k++) begin
						case ($urandom_range(0, 3))
							0: ch = b64sc_pkg::PadChar;
							1: ch = 8'($urandom_range(0, 255));
							default: ch = b64_chars[$urandom_range(0, 63)];
						endcase
						send_beat(ch, k == len - 1, 1);
					end
				end
				if ($urandom_range(0, 5) == 0) drain_out();
			end
			// Leave a partial group behind now and then; the mode write must clear it.
			if ($urandom_range(0, 2) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1);
			phase++;
		end

		drain_out();
		repeat (20) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("PASS base64_stream_codec");
		end else begin
			$display("FAIL base64_stream_codec");
		end
		$finish;
	end

endmodule
